/* rtl/core/lwm_pkg.sv */
`default_nettype none

package lwm_pkg;

  // field widths
  localparam int unsigned X_W          = 8;
  localparam int unsigned NUM_LAYERS   = 6;
  localparam int unsigned NUM_SCR_LYR  = 5;
  localparam int unsigned COLOR_LAYER  = 5;
  localparam int unsigned SEL_W        = 4 * NUM_LAYERS;
  localparam int unsigned LOGIC_W      = 2 * NUM_LAYERS;
  localparam int unsigned SCR_EN_W     = 2 * NUM_SCR_LYR;
  localparam int unsigned CMODE_W      = 4;

  // stream and configuration port widths
  localparam int unsigned IN_TDATA_W   = 8;
  localparam int unsigned OUT_TDATA_W  = 16;
  localparam int unsigned CFG_IDX_W    = 4;
  localparam int unsigned CFG_DATA_W   = 24;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIN_ONE_LEFT   = 4'd0,
    REG_WIN_ONE_RIGHT  = 4'd1,
    REG_WIN_TWO_LEFT   = 4'd2,
    REG_WIN_TWO_RIGHT  = 4'd3,
    REG_LAYER_SELECT   = 4'd4,
    REG_LAYER_LOGIC    = 4'd5,
    REG_SCREEN_ENABLE  = 4'd6,
    REG_COLOR_MODE     = 4'd7
  } reg_idx_t;

  // window combine operations
  typedef enum logic [1:0] {
    WLOG_OR   = 2'd0,
    WLOG_AND  = 2'd1,
    WLOG_XOR  = 2'd2,
    WLOG_XNOR = 2'd3
  } win_logic_t;

  // color window modes
  typedef enum logic [1:0] {
    CMODE_ALWAYS  = 2'd0,
    CMODE_INSIDE  = 2'd1,
    CMODE_OUTSIDE = 2'd2,
    CMODE_NEVER   = 2'd3
  } color_mode_t;

  // per-layer window result between combine stage and masking stage
  typedef struct packed {
    logic [NUM_LAYERS-1:0] hit;
    logic [NUM_LAYERS-1:0] any;
  } layer_win_t;

endpackage

`default_nettype wire

/* rtl/core/lwm_combine.sv */
`default_nettype none

module lwm_combine (
  input  wire logic                       w1_in,
  input  wire logic                       w2_in,
  input  wire logic [lwm_pkg::SEL_W-1:0]  layer_select,
  input  wire logic [lwm_pkg::LOGIC_W-1:0] layer_logic,
  output lwm_pkg::layer_win_t             win
);
  import lwm_pkg::*;

  // per layer: invert, then pick single window, combine both, or none
  always_comb begin
    logic       en1, en2, w1, w2;
    win_logic_t op;
    win = '0;
    for (int l = 0; l < NUM_LAYERS; l++) begin
      en1 = layer_select[4*l];
      en2 = layer_select[4*l+2];
      w1  = w1_in ^ layer_select[4*l+1];
      w2  = w2_in ^ layer_select[4*l+3];
      op  = win_logic_t'(layer_logic[2*l +: 2]);
      win.any[l] = en1 | en2;
      if (en1 && !en2) begin
        win.hit[l] = w1;
      end else if (!en1 && en2) begin
        win.hit[l] = w2;
      end else if (!en1 && !en2) begin
        win.hit[l] = 1'b0;
      end else begin
        case (op)
          WLOG_OR:   win.hit[l] = w1 | w2;
          WLOG_AND:  win.hit[l] = w1 & w2;
          WLOG_XOR:  win.hit[l] = w1 ^ w2;
          default:   win.hit[l] = ~(w1 ^ w2);
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/layer_window_mask_unit.sv */
`default_nettype none

// Layer window mask unit: for each pixel column request it returns, for four
// backgrounds, sprites and the color window, whether the pixel is masked on
// the main and on the sub screen. It is a three-stage pipeline (window edge
// compares, per-layer window combine, screen enable and color mode masking)
// that takes one request per clock while the result side does not stall;
// backpressure on the result side stalls all stages without loss.
// Window registers are written through the cfg channel, which is always
// ready; write them only while no request is in flight.

module layer_window_mask_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // in_tdata: [7:0] pixel_x
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [lwm_pkg::IN_TDATA_W-1:0]     in_tdata,
  // out_tdata: [5:0] main_layer_mask, [11:6] sub_layer_mask, [15:12] zero
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [lwm_pkg::OUT_TDATA_W-1:0]         out_tdata,
  // configuration write channel
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [lwm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [lwm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lwm_pkg::*;

  // configuration registers
  logic [X_W-1:0]      w1_left_r, w1_right_r, w2_left_r, w2_right_r;
  logic [SEL_W-1:0]    sel_r;
  logic [LOGIC_W-1:0]  logic_r;
  logic [SCR_EN_W-1:0] scr_en_r;
  logic [CMODE_W-1:0]  cmode_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w1_left_r  <= '0;
      w1_right_r <= '0;
      w2_left_r  <= '0;
      w2_right_r <= '0;
      sel_r      <= '0;
      logic_r    <= '0;
      scr_en_r   <= '0;
      cmode_r    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIN_ONE_LEFT:  w1_left_r  <= cfg_data[X_W-1:0];
        REG_WIN_ONE_RIGHT: w1_right_r <= cfg_data[X_W-1:0];
        REG_WIN_TWO_LEFT:  w2_left_r  <= cfg_data[X_W-1:0];
        REG_WIN_TWO_RIGHT: w2_right_r <= cfg_data[X_W-1:0];
        REG_LAYER_SELECT:  sel_r      <= cfg_data[SEL_W-1:0];
        REG_LAYER_LOGIC:   logic_r    <= cfg_data[LOGIC_W-1:0];
        REG_SCREEN_ENABLE: scr_en_r   <= cfg_data[SCR_EN_W-1:0];
        REG_COLOR_MODE:    cmode_r    <= cfg_data[CMODE_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control: a stage loads when empty or when it drains
  logic s1_v_r, s2_v_r, s3_v_r;
  logic ld1, ld2, ld3;

  assign ld3 = !s3_v_r || out_tready;
  assign ld2 = !s2_v_r || ld3;
  assign ld1 = !s1_v_r || ld2;
  assign in_tready = ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (ld1) s1_v_r <= in_tvalid;
      if (ld2) s2_v_r <= s1_v_r;
      if (ld3) s3_v_r <= s2_v_r;
    end
  end

  // stage 1: window edge compares
  logic [X_W-1:0] px;
  logic           w1_nxt, w2_nxt;
  logic           w1_r, w2_r;

  assign px     = in_tdata[X_W-1:0];
  assign w1_nxt = (px >= w1_left_r) && (px <= w1_right_r);
  assign w2_nxt = (px >= w2_left_r) && (px <= w2_right_r);

  always_ff @(posedge clk) begin
    if (ld1) begin
      w1_r <= w1_nxt;
      w2_r <= w2_nxt;
    end
  end

  // stage 2: per-layer window combine
  layer_win_t win_nxt, win_r;

  lwm_combine u_combine (
    .w1_in        (w1_r),
    .w2_in        (w2_r),
    .layer_select (sel_r),
    .layer_logic  (logic_r),
    .win          (win_nxt)
  );

  always_ff @(posedge clk) begin
    if (ld2) win_r <= win_nxt;
  end

  // stage 3: screen enables and color window mode
  logic [NUM_LAYERS-1:0] main_nxt, sub_nxt, main_r, sub_r;

  function automatic logic color_bit(input logic [1:0] mode_bits, input logic any,
                                     input logic hit);
    color_mode_t mode;
    logic        res;
    mode = color_mode_t'(mode_bits);
    case (mode)
      CMODE_ALWAYS:  res = 1'b1;
      CMODE_INSIDE:  res = any & hit;
      CMODE_OUTSIDE: res = ~(any & hit);
      default:       res = 1'b0;
    endcase
    return res;
  endfunction

  always_comb begin
    for (int l = 0; l < NUM_SCR_LYR; l++) begin
      main_nxt[l] = scr_en_r[l] & win_r.any[l] & win_r.hit[l];
      sub_nxt[l]  = scr_en_r[NUM_SCR_LYR+l] & win_r.any[l] & win_r.hit[l];
    end
    main_nxt[COLOR_LAYER] = color_bit(cmode_r[1:0], win_r.any[COLOR_LAYER],
                                      win_r.hit[COLOR_LAYER]);
    sub_nxt[COLOR_LAYER]  = color_bit(cmode_r[3:2], win_r.any[COLOR_LAYER],
                                      win_r.hit[COLOR_LAYER]);
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      main_r <= main_nxt;
      sub_r  <= sub_nxt;
    end
  end

  // result channel
  assign out_tvalid = s3_v_r;
  assign out_tdata  = {{(OUT_TDATA_W - 2*NUM_LAYERS){1'b0}}, sub_r, main_r};

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import lwm_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int NUM_PHASES   = 20;
  localparam int PHASE_PIXELS = 100;
  localparam int STALL_CYCLES = 300;
  localparam int DRAIN_CYCLES = 4;
  // register indexes past the last real register, ignored by the block
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 4'd8;

  // window register shadow used for prediction
  typedef struct {
    logic [X_W-1:0]      w1_left;
    logic [X_W-1:0]      w1_right;
    logic [X_W-1:0]      w2_left;
    logic [X_W-1:0]      w2_right;
    logic [SEL_W-1:0]    sel;
    logic [LOGIC_W-1:0]  wlogic;
    logic [SCR_EN_W-1:0] scr_en;
    logic [CMODE_W-1:0]  cmode;
  } win_regs_t;

  typedef struct {
    logic [X_W-1:0]        px;
    logic [NUM_LAYERS-1:0] main_mask;
    logic [NUM_LAYERS-1:0] sub_mask;
  } mask_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic in_fire = 1'b0;
  logic cfg_fire = 1'b0;

  win_regs_t       win_regs;
  logic [X_W-1:0]  pixel_q[$];
  mask_rec_t       mask_expect_q[$];

  int send_idle_pct = 25;
  int recv_idle_pct = 69;
  int stall_ask = 0;
  int stall_seen = 0;
  int stall_left = 0;
  int mismatch_cnt = 0;
  int results_checked = 0;
  int pixels_accepted = 0;
  int settings_used = 0;

  layer_window_mask_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  always #(CLK_PERIOD / 2) clk = ~clk;

  // color layer bit from its screen mode
  function automatic logic color_masked(color_mode_t mode, logic win_any, logic hit);
    case (mode)
      CMODE_ALWAYS:  return 1'b1;
      CMODE_NEVER:   return 1'b0;
      CMODE_INSIDE:  return win_any & hit;
      default:       return ~(win_any & hit);
    endcase
  endfunction

  // masks of all six layers on both screens for one pixel column
  function automatic mask_rec_t predict_masks(win_regs_t r, logic [X_W-1:0] x);
    mask_rec_t  rec;
    logic [3:0] sel;
    win_logic_t op;
    logic       in1, in2, en1, en2, win_any, hit;
    int         lyr;
    rec.px = x;
    rec.main_mask = '0;
    rec.sub_mask = '0;
    for (lyr = 0; lyr < NUM_LAYERS; lyr++) begin
      sel = r.sel[4*lyr +: 4];
      op  = win_logic_t'(r.wlogic[2*lyr +: 2]);
      // inclusive edges, a reversed window holds no pixel
      in1 = (x >= r.w1_left) && (x <= r.w1_right);
      in2 = (x >= r.w2_left) && (x <= r.w2_right);
      in1 = in1 ^ sel[1];
      in2 = in2 ^ sel[3];
      en1 = sel[0];
      en2 = sel[2];
      win_any = en1 | en2;
      if (en1 && !en2) hit = in1;
      else if (!en1 && en2) hit = in2;
      else if (!win_any) hit = 1'b0;
      else begin
        case (op)
          WLOG_OR:  hit = in1 | in2;
          WLOG_AND: hit = in1 & in2;
          WLOG_XOR: hit = in1 ^ in2;
          default:  hit = ~(in1 ^ in2);
        endcase
      end
      if (lyr != COLOR_LAYER) begin
        rec.main_mask[lyr] = r.scr_en[lyr] & win_any & hit;
        rec.sub_mask[lyr]  = r.scr_en[NUM_SCR_LYR + lyr] & win_any & hit;
      end else begin
        rec.main_mask[lyr] = color_masked(color_mode_t'(r.cmode[1:0]), win_any, hit);
        rec.sub_mask[lyr]  = color_masked(color_mode_t'(r.cmode[3:2]), win_any, hit);
      end
    end
    return rec;
  endfunction

  // pixel column biased toward the current window edges
  function automatic logic [X_W-1:0] pick_pixel();
    logic [X_W-1:0] brink;
    case ($urandom_range(7))
      0: brink = win_regs.w1_left;
      1: brink = win_regs.w1_right;
      2: brink = win_regs.w2_left;
      3: brink = win_regs.w2_right;
      default: return X_W'($urandom_range(255));
    endcase
    return brink + X_W'($urandom_range(2)) - X_W'(1);
  endfunction

  // window edge, extremes more often than plain random
  function automatic logic [X_W-1:0] pick_edge();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return X_W'($urandom_range(255));
    endcase
  endfunction

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tdata  <= pixel_q.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver, with long hold-offs on request
  always @(negedge clk) begin
    if (stall_ask != stall_seen) begin
      stall_seen = stall_ask;
      stall_left = STALL_CYCLES;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: register shadow, prediction and result check
  always @(posedge clk) begin
    mask_rec_t exp_r;
    in_fire  <= rst_n && in_tvalid && in_tready;
    cfg_fire <= rst_n && cfg_valid && cfg_ready;
    if (!rst_n) begin
      win_regs = '{default: '0};
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WIN_ONE_LEFT:  win_regs.w1_left  = cfg_data[X_W-1:0];
          REG_WIN_ONE_RIGHT: win_regs.w1_right = cfg_data[X_W-1:0];
          REG_WIN_TWO_LEFT:  win_regs.w2_left  = cfg_data[X_W-1:0];
          REG_WIN_TWO_RIGHT: win_regs.w2_right = cfg_data[X_W-1:0];
          REG_LAYER_SELECT:  win_regs.sel      = cfg_data[SEL_W-1:0];
          REG_LAYER_LOGIC:   win_regs.wlogic   = cfg_data[LOGIC_W-1:0];
          REG_SCREEN_ENABLE: win_regs.scr_en   = cfg_data[SCR_EN_W-1:0];
          REG_COLOR_MODE:    win_regs.cmode    = cfg_data[CMODE_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        mask_expect_q.push_back(predict_masks(win_regs, in_tdata));
        pixels_accepted++;
      end
      if (out_tvalid && out_tready) begin
        if (mask_expect_q.size() == 0) begin
          $display("%0t: unexpected result, none pending: out_tdata=%h", $time, out_tdata);
          mismatch_cnt++;
        end else begin
          exp_r = mask_expect_q.pop_front();
          results_checked++;
          if (out_tdata[NUM_LAYERS-1:0] !== exp_r.main_mask) begin
            $display("%0t: x=%0d main_layer_mask expected %b actual %b", $time,
                     exp_r.px, exp_r.main_mask, out_tdata[NUM_LAYERS-1:0]);
            mismatch_cnt++;
          end
          if (out_tdata[2*NUM_LAYERS-1:NUM_LAYERS] !== exp_r.sub_mask) begin
            $display("%0t: x=%0d sub_layer_mask expected %b actual %b", $time,
                     exp_r.px, exp_r.sub_mask, out_tdata[2*NUM_LAYERS-1:NUM_LAYERS]);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // one register write over the cfg channel
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
  endtask

  // full window setup; unused upper data bits carry junk, plus a spare index
  task automatic load_setting(logic [X_W-1:0] w1l, logic [X_W-1:0] w1r,
                              logic [X_W-1:0] w2l, logic [X_W-1:0] w2r,
                              logic [SEL_W-1:0] sel, logic [LOGIC_W-1:0] wlogic,
                              logic [SCR_EN_W-1:0] scr_en, logic [CMODE_W-1:0] cmode);
    write_reg(REG_WIN_ONE_LEFT,  {16'($urandom), w1l});
    write_reg(REG_WIN_ONE_RIGHT, {16'($urandom), w1r});
    write_reg(REG_WIN_TWO_LEFT,  {16'($urandom), w2l});
    write_reg(REG_WIN_TWO_RIGHT, {16'($urandom), w2r});
    write_reg(REG_LAYER_SELECT,  sel);
    write_reg(REG_LAYER_LOGIC,   {12'($urandom), wlogic});
    write_reg(REG_SCREEN_ENABLE, {14'($urandom), scr_en});
    write_reg(REG_COLOR_MODE,    {20'($urandom), cmode});
    write_reg(REG_SPARE_FIRST + CFG_IDX_W'($urandom_range(7)), CFG_DATA_W'($urandom));
    settings_used++;
  endtask

  task automatic load_random_setting();
    logic [SCR_EN_W-1:0] scr_en;
    scr_en = ($urandom_range(3) == 0) ? '1 : SCR_EN_W'($urandom);
    load_setting(pick_edge(), pick_edge(), pick_edge(), pick_edge(),
                 SEL_W'($urandom), LOGIC_W'($urandom), scr_en, CMODE_W'($urandom));
  endtask

  task automatic queue_pixels(int count);
    int i;
    @(posedge clk);
    for (i = 0; i < count; i++) pixel_q.push_back(pick_pixel());
  endtask

  // block idle: nothing queued, offered or pending, then pipeline drain time
  // checked at the rising edge, where the driver's outputs are settled
  task automatic wait_drained();
    do @(posedge clk);
    while (pixel_q.size() != 0 || in_tvalid || mask_expect_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // stimulus
  initial begin
    int ph;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // reset values: no windows, color always masked
    @(posedge clk);
    pixel_q.push_back(8'd0);
    pixel_q.push_back(8'd255);
    wait_drained();

    // overlapping windows, each combine op on its own layer
    load_setting(8'd10, 8'd20, 8'd15, 8'd30, 24'h555555,
                 {WLOG_AND, WLOG_OR, WLOG_XNOR, WLOG_XOR, WLOG_AND, WLOG_OR},
                 '1, {CMODE_OUTSIDE, CMODE_INSIDE});
    @(posedge clk);
    pixel_q.push_back(8'd0);
    pixel_q.push_back(8'd12);
    pixel_q.push_back(8'd17);
    pixel_q.push_back(8'd25);
    pixel_q.push_back(8'd255);
    wait_drained();

    // empty windows, single window and inverts, colour layer with none enabled
    load_setting(8'd200, 8'd100, 8'd255, 8'd0, 24'h00C431,
                 {WLOG_OR, WLOG_OR, WLOG_OR, WLOG_OR, WLOG_OR, WLOG_OR},
                 10'h01F, {CMODE_NEVER, CMODE_OUTSIDE});
    @(posedge clk);
    pixel_q.push_back(8'd0);
    pixel_q.push_back(8'd150);
    pixel_q.push_back(8'd255);
    wait_drained();

    // full-line and single-pixel windows, sub screen only
    load_setting(8'd0, 8'd255, 8'd255, 8'd255, 24'hF5A5F5,
                 {WLOG_XNOR, WLOG_XOR, WLOG_AND, WLOG_OR, WLOG_XNOR, WLOG_XOR},
                 10'h3E0, {CMODE_INSIDE, CMODE_NEVER});
    @(posedge clk);
    pixel_q.push_back(8'd0);
    pixel_q.push_back(8'd254);
    pixel_q.push_back(8'd255);
    wait_drained();

    // colour always on main, outside on sub
    load_setting(8'd64, 8'd127, 8'd100, 8'd200, 24'hFFFFFF,
                 {WLOG_OR, WLOG_AND, WLOG_XOR, WLOG_XNOR, WLOG_OR, WLOG_AND},
                 10'h2AA, {CMODE_OUTSIDE, CMODE_ALWAYS});
    @(posedge clk);
    pixel_q.push_back(8'd63);
    pixel_q.push_back(8'd64);
    pixel_q.push_back(8'd127);
    pixel_q.push_back(8'd201);
    wait_drained();

    // random settings and pixels, idle profile changes by phase
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < NUM_PHASES / 3) begin
        send_idle_pct = 25;
        recv_idle_pct = 69;
      end else if (ph < 2 * NUM_PHASES / 3) begin
        send_idle_pct = 69;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      load_random_setting();
      if (ph == 10) begin
        // sender holds back until every result is in
        queue_pixels(PHASE_PIXELS / 2);
        wait_drained();
        queue_pixels(PHASE_PIXELS / 2);
      end else begin
        queue_pixels(PHASE_PIXELS);
        // receiver holds off while requests keep coming
        if (ph == 3 || ph == NUM_PHASES - 2) stall_ask++;
      end
      wait_drained();
    end

    repeat (10) @(negedge clk);
    $display("checked %0d mask results from %0d pixel requests over %0d window settings",
             results_checked, pixels_accepted, settings_used);
    $display("all combine ops, color modes, empty and full windows, stalls and pauses hit");
    if (mismatch_cnt == 0 && mask_expect_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #(2_000_000);
    $display("timeout with %0d results pending", mask_expect_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
